[hdl/lotsch_pkg.sv]
`timescale 1ns / 1ps

package lotsch_pkg;

    // field widths fixed by the interface
    localparam int PID_W   = 16;
    localparam int TIX_W   = 16;
    localparam int SLOT_W  = PID_W + TIX_W;
    localparam int RAND_W  = 32;
    localparam int IDX_OUT_W = 6;
    localparam int SUM_OUT_W = 22;

    // one dividend bit per divider step
    localparam int DIV_STEPS = RAND_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // lfsr113 seed and component masks
    localparam logic [RAND_W-1:0] RNG_SEED = 32'd12345;
    localparam logic [RAND_W-1:0] MASK_Z1  = 32'd4294967294;
    localparam logic [RAND_W-1:0] MASK_Z2  = 32'd4294967288;
    localparam logic [RAND_W-1:0] MASK_Z3  = 32'd4294967280;
    localparam logic [RAND_W-1:0] MASK_Z4  = 32'd4294967168;

    // request codes
    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_PICK   = 2'd2
    } t_req;

    // control states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_CHG,
        ST_SUM,
        ST_RNG,
        ST_DIV,
        ST_SEL,
        ST_RESP
    } t_state;

endpackage

[hdl/lottery_scheduler_lfsr113_unit.sv]
`timescale 1ns / 1ps

// Lottery scheduler over NUM_SLOTS process slots kept in one synchronous RAM
// (id and tickets per slot, registered read) with a valid bit and a
// runnable flag per slot in flops. One request is in work at a time; a new
// request is taken while the previous result still waits at the output.
// A set-entry request writes its slot in ST_SET and then responds; an unknown
// request code responds at once. A change-tickets request walks the RAM one
// slot per cycle and stops at the first id match. A pick walks the RAM once
// to sum the runnable tickets, steps the lfsr113 generator once in ST_RNG,
// reduces its output modulo the sum with a restoring divider that makes one
// bit per cycle, then walks the RAM again to the winning slot; an empty pick
// returns after the first walk. The result is raised once the output register
// is free, and the state returns to idle on that same edge, so the next
// request can be taken at once.
module lottery_scheduler_lfsr113_unit
    import lotsch_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [5:0]           i_entry_index,
    input  logic [PID_W-1:0]     i_proc_id,
    input  logic [TIX_W-1:0]     i_ticket_value,
    input  logic                 i_runnable_in,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_grant_valid,
    output logic [IDX_OUT_W-1:0] o_grant_index,
    output logic [PID_W-1:0]     o_grant_pid,
    output logic                 o_id_found,
    output logic [SUM_OUT_W-1:0] o_ticket_total,
    output logic [SUM_OUT_W-1:0] o_draw_value
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int SUM_W = TIX_W + IDX_W;
    localparam logic [IDX_W:0]   SLOT_CNT  = (IDX_W + 1)'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DIV_STEPS - 1);

    t_state r_state, n_state;

    // latched request
    logic [1:0]       r_req_type, n_req_type;
    logic [5:0]       r_idx, n_idx;
    logic [PID_W-1:0] r_pid, n_pid;
    logic [TIX_W-1:0] r_tix, n_tix;
    logic             r_run_in, n_run_in;

    // per-slot flags
    logic [NUM_SLOTS-1:0] r_vld, n_vld;
    logic [NUM_SLOTS-1:0] r_run, n_run;

    // generator
    logic [RAND_W-1:0] r_z1, n_z1, r_z2, n_z2, r_z3, n_z3, r_z4, n_z4;

    // table walk
    logic [IDX_W:0]    r_ra, n_ra;
    logic              r_dv, n_dv;
    logic [IDX_W-1:0]  r_di, n_di;
    logic              r_rd_ok;
    logic [SLOT_W-1:0] r_rd_q;

    // pick datapath
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [RAND_W-1:0] r_dvd, n_dvd;
    logic [SUM_W:0]    r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // result in work
    logic             r_found, n_found;
    logic             r_gnt, n_gnt;
    logic [IDX_W-1:0] r_gidx, n_gidx;
    logic [PID_W-1:0] r_gpid, n_gpid;

    // output register
    logic                 r_o_vld, n_o_vld;
    logic                 r_o_gv, n_o_gv;
    logic [IDX_OUT_W-1:0] r_o_gi, n_o_gi;
    logic [PID_W-1:0]     r_o_pid, n_o_pid;
    logic                 r_o_found, n_o_found;
    logic [SUM_OUT_W-1:0] r_o_total, n_o_total;
    logic [SUM_OUT_W-1:0] r_o_draw, n_o_draw;

    // ram port
    logic              w_we;
    logic [IDX_W-1:0]  w_wa;
    logic [SLOT_W-1:0] w_wd;
    logic [IDX_W-1:0]  w_ra;
    logic [SLOT_W-1:0] r_mem [NUM_SLOTS];

    // helpers
    logic              w_issue;
    logic              w_last;
    logic [PID_W-1:0]  w_rd_pid;
    logic [TIX_W-1:0]  w_rd_tix;
    logic [SUM_W-1:0]  w_sum_add;
    logic [SUM_W-1:0]  w_acc_add;
    logic [SUM_W:0]    w_shift;
    logic [RAND_W-1:0] w_b1, w_b2, w_b3, w_b4;
    logic [RAND_W-1:0] w_z1, w_z2, w_z3, w_z4;
    logic [31:0]       w_set_wide;
    logic              w_set_ok;
    logic [31:0]       w_gidx_wide;
    logic [31:0]       w_sum_wide;
    logic [31:0]       w_draw_wide;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_o_vld;
    assign o_grant_valid  = r_o_gv;
    assign o_grant_index  = r_o_gi;
    assign o_grant_pid    = r_o_pid;
    assign o_id_found     = r_o_found;
    assign o_ticket_total = r_o_total;
    assign o_draw_value   = r_o_draw;

    // masked read data, never-written slots read as zero
    assign w_rd_pid  = r_rd_ok ? r_rd_q[SLOT_W-1:TIX_W] : '0;
    assign w_rd_tix  = r_rd_ok ? r_rd_q[TIX_W-1:0] : '0;
    assign w_last    = r_dv && (r_di == SLOT_LAST);
    assign w_sum_add = r_sum + SUM_W'(w_rd_tix);
    assign w_acc_add = r_acc + SUM_W'(w_rd_tix);
    assign w_shift   = {r_rem[SUM_W-1:0], r_dvd[RAND_W-1]};
    assign w_ra      = r_ra[IDX_W-1:0];

    assign w_set_wide  = 32'(r_idx);
    assign w_set_ok    = (w_set_wide < NUM_SLOTS);
    assign w_gidx_wide = 32'(r_gidx);
    assign w_sum_wide  = 32'(r_sum);
    assign w_draw_wide = 32'(r_rem[SUM_W-1:0]);

    // lfsr113 step
    assign w_b1 = ((r_z1 << 6) ^ r_z1) >> 13;
    assign w_z1 = ((r_z1 & MASK_Z1) << 18) ^ w_b1;
    assign w_b2 = ((r_z2 << 2) ^ r_z2) >> 27;
    assign w_z2 = ((r_z2 & MASK_Z2) << 2) ^ w_b2;
    assign w_b3 = ((r_z3 << 13) ^ r_z3) >> 21;
    assign w_z3 = ((r_z3 & MASK_Z3) << 7) ^ w_b3;
    assign w_b4 = ((r_z4 << 3) ^ r_z4) >> 12;
    assign w_z4 = ((r_z4 & MASK_Z4) << 13) ^ w_b4;

    // slot ram
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_q <= r_mem[w_ra];
    end

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_req_type = r_req_type;
        n_idx      = r_idx;
        n_pid      = r_pid;
        n_tix      = r_tix;
        n_run_in   = r_run_in;
        n_vld      = r_vld;
        n_run      = r_run;
        n_z1       = r_z1;
        n_z2       = r_z2;
        n_z3       = r_z3;
        n_z4       = r_z4;
        n_ra       = r_ra;
        n_dv       = 1'b0;
        n_di       = r_di;
        n_sum      = r_sum;
        n_acc      = r_acc;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_gnt      = r_gnt;
        n_gidx     = r_gidx;
        n_gpid     = r_gpid;
        n_o_vld    = r_o_vld;
        n_o_gv     = r_o_gv;
        n_o_gi     = r_o_gi;
        n_o_pid    = r_o_pid;
        n_o_found  = r_o_found;
        n_o_total  = r_o_total;
        n_o_draw   = r_o_draw;
        w_we       = 1'b0;
        w_wa       = r_di;
        w_wd       = {w_rd_pid, r_tix};
        w_issue    = 1'b0;

        // result taken downstream
        if (r_o_vld && i_out_ready) begin
            n_o_vld = 1'b0;
        end

        // walk issue, one read per cycle
        if (r_state == ST_CHG || r_state == ST_SUM || r_state == ST_SEL) begin
            w_issue = (r_ra < SLOT_CNT);
            if (w_issue) begin
                n_ra = r_ra + 1'b1;
            end
            n_dv = w_issue;
            n_di = r_ra[IDX_W-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req_type = i_req_type;
                    n_idx      = i_entry_index;
                    n_pid      = i_proc_id;
                    n_tix      = i_ticket_value;
                    n_run_in   = i_runnable_in;
                    n_ra       = '0;
                    n_sum      = '0;
                    n_acc      = '0;
                    n_rem      = '0;
                    n_found    = 1'b0;
                    n_gnt      = 1'b0;
                    n_gidx     = '0;
                    n_gpid     = '0;
                    case (i_req_type)
                        REQ_SET:    n_state = ST_SET;
                        REQ_CHANGE: n_state = ST_CHG;
                        REQ_PICK:   n_state = ST_SUM;
                        default:    n_state = ST_RESP;
                    endcase
                end
            end
            ST_SET: begin
                if (w_set_ok) begin
                    w_we        = 1'b1;
                    w_wa        = w_set_wide[IDX_W-1:0];
                    w_wd        = {r_pid, r_tix};
                    n_vld[w_wa] = 1'b1;
                    n_run[w_wa] = r_run_in;
                end
                n_state = ST_RESP;
            end
            ST_CHG: begin
                // first id match gets the new ticket count
                if (r_dv && (w_rd_pid == r_pid)) begin
                    w_we        = 1'b1;
                    w_wa        = r_di;
                    w_wd        = {w_rd_pid, r_tix};
                    n_vld[r_di] = 1'b1;
                    n_found     = 1'b1;
                    n_state     = ST_RESP;
                end else if (w_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_SUM: begin
                if (r_dv && r_run[r_di]) begin
                    n_sum = w_sum_add;
                end
                if (w_last) begin
                    n_ra = '0;
                    n_dv = 1'b0;
                    if (n_sum == '0) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_RNG;
                    end
                end
            end
            ST_RNG: begin
                n_z1    = w_z1;
                n_z2    = w_z2;
                n_z3    = w_z3;
                n_z4    = w_z4;
                n_dvd   = w_z1 ^ w_z2 ^ w_z3 ^ w_z4;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // restoring remainder, one dividend bit per cycle
                if (w_shift >= {1'b0, r_sum}) begin
                    n_rem = w_shift - {1'b0, r_sum};
                end else begin
                    n_rem = w_shift;
                end
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_ra    = '0;
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                // running total first above the draw wins
                if (r_dv && r_run[r_di]) begin
                    n_acc = w_acc_add;
                    if (w_acc_add > r_rem[SUM_W-1:0]) begin
                        n_gnt       = 1'b1;
                        n_gidx      = r_di;
                        n_gpid      = w_rd_pid;
                        n_run[r_di] = 1'b0;
                        n_state     = ST_RESP;
                    end else if (w_last) begin
                        n_state = ST_RESP;
                    end
                end else if (w_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_o_vld || i_out_ready) begin
                    n_o_vld   = 1'b1;
                    n_o_gv    = r_gnt;
                    n_o_gi    = r_gnt ? w_gidx_wide[IDX_OUT_W-1:0] : '0;
                    n_o_pid   = r_gnt ? r_gpid : '0;
                    n_o_found = r_found;
                    n_o_total = w_sum_wide[SUM_OUT_W-1:0];
                    n_o_draw  = w_draw_wide[SUM_OUT_W-1:0];
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld   <= '0;
            r_run   <= '0;
            r_z1    <= RNG_SEED;
            r_z2    <= RNG_SEED;
            r_z3    <= RNG_SEED;
            r_z4    <= RNG_SEED;
            r_dv    <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_run   <= n_run;
            r_z1    <= n_z1;
            r_z2    <= n_z2;
            r_z3    <= n_z3;
            r_z4    <= n_z4;
            r_dv    <= n_dv;
            r_o_vld <= n_o_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_idx      <= n_idx;
        r_pid      <= n_pid;
        r_tix      <= n_tix;
        r_run_in   <= n_run_in;
        r_ra       <= n_ra;
        r_di       <= n_di;
        r_rd_ok    <= r_vld[w_ra];
        r_sum      <= n_sum;
        r_acc      <= n_acc;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_gnt      <= n_gnt;
        r_gidx     <= n_gidx;
        r_gpid     <= n_gpid;
        r_o_gv     <= n_o_gv;
        r_o_gi     <= n_o_gi;
        r_o_pid    <= n_o_pid;
        r_o_found  <= n_o_found;
        r_o_total  <= n_o_total;
        r_o_draw   <= n_o_draw;
    end

    // draw stays below the ticket sum during selection
    a_draw_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEL) |-> (r_rem[SUM_W-1:0] < r_sum))
        else $error("draw not below ticket sum");

    // a result never carries both a grant and an id match
    a_grant_or_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> !(r_o_gv && r_o_found))
        else $error("grant and id match in one result");

    // granted slot leaves the runnable set
    a_grant_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEL && n_state == ST_RESP && n_gnt) |=> !r_run[r_gidx])
        else $error("granted slot still runnable");

endmodule
